// ===== hw/rtl/lsbse_pkg.sv =====
// shared types, codes and constants of the lsb stego embedder
package lsbse_pkg;

  localparam int MSG_DEPTH_DEF = 256;
  localparam int NUM_LANES     = 3;
  localparam int IN_DATA_W     = 40;
  localparam int OUT_DATA_W    = 40;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_PIXEL  = 2'd2
  } func_t;

  // per-channel embed control
  typedef struct packed {
    logic       en;
    logic       hi;      // bit comes from the following byte
    logic [2:0] bitnum;  // bit inside the byte, msb first
  } lane_ctl_t;

  // pixel and status carried through the read stage
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] used;
    logic       done;
    logic       ovf;
    logic       pix;
  } s1_t;

endpackage

// ===== hw/rtl/lsbse_ctrl.sv =====
// message store, bit position tracking and lane control for the read stage
module lsbse_ctrl import lsbse_pkg::*; #(
  parameter int MSG_DEPTH = MSG_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_func,
  input  logic [7:0]      msg_byte,
  input  logic [7:0]      red_in,
  input  logic [7:0]      green_in,
  input  logic [7:0]      blue_in,
  input  logic [7:0]      alpha_in,
  input  logic            last_pixel,
  input  logic            s2_ready,
  output logic            s1_valid,
  output s1_t             s1,
  output lane_ctl_t       lane_ctl [NUM_LANES],
  output logic [7:0]      byte0,
  output logic [7:0]      byte1
);

  localparam int LW = $clog2(MSG_DEPTH + 1);
  localparam int AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
  localparam int BW = $clog2((MSG_DEPTH + 1) * 8 + 1);

  logic [LW-1:0] len_r, len_nxt;
  logic [BW-1:0] bp_r, bp_nxt, bp_adv;
  logic [BW-1:0] total, idx0, idx1;
  logic          s1_valid_r;
  logic          in_fire, wr_en, ovf, done, m0, m1, m0_r, m1_r;
  logic [1:0]    used;
  lane_ctl_t     ctl      [NUM_LANES];
  lane_ctl_t     ctl_r    [NUM_LANES];
  s1_t           s1_r;
  func_t         fn;
  logic [7:0]    mem [MSG_DEPTH];
  logic [7:0]    rd0_r, rd1_r;

  assign in_ready = !s1_valid_r || s2_ready;
  assign in_fire  = in_valid && in_ready;
  assign fn       = func_t'(in_func);
  assign total    = (BW'(len_r) + BW'(1)) << 3;
  assign idx0     = bp_r >> 3;
  assign idx1     = idx0 + BW'(1);
  // bytes past the stored message read as the zero terminator
  assign m0       = idx0 < BW'(len_r);
  assign m1       = idx1 < BW'(len_r);

  always_comb begin
    logic [BW:0] pos;
    logic [3:0]  sub;
    used = 2'd0;
    for (int i = 0; i < NUM_LANES; i++) begin
      pos              = {1'b0, bp_r} + (BW+1)'(i);
      sub              = {1'b0, bp_r[2:0]} + 4'(i);
      ctl[i].en        = pos < {1'b0, total};
      ctl[i].hi        = sub[3];
      ctl[i].bitnum    = 3'd7 - sub[2:0];
      used             = used + {1'b0, ctl[i].en};
    end
  end

  always_comb begin
    len_nxt = len_r;
    bp_adv  = bp_r;
    ovf     = 1'b0;
    wr_en   = 1'b0;
    unique case (fn)
      FUNC_START: begin
        len_nxt = '0;
        bp_adv  = '0;
      end
      FUNC_APPEND: begin
        if (len_r < LW'(MSG_DEPTH)) begin
          len_nxt = len_r + LW'(1);
          wr_en   = 1'b1;
        end else begin
          ovf = 1'b1;
        end
      end
      FUNC_PIXEL: begin
        bp_adv = bp_r + BW'(used);
      end
      default: ;
    endcase
    done   = bp_adv >= ((BW'(len_nxt) + BW'(1)) << 3);
    // last pixel rewinds after the flag is taken
    bp_nxt = (fn == FUNC_PIXEL && last_pixel) ? '0 : bp_adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      bp_r       <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_fire;
      if (in_fire) begin
        len_r <= len_nxt;
        bp_r  <= bp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.red   <= red_in;
      s1_r.green <= green_in;
      s1_r.blue  <= blue_in;
      s1_r.alpha <= alpha_in;
      s1_r.used  <= (fn == FUNC_PIXEL) ? used : 2'd0;
      s1_r.done  <= done;
      s1_r.ovf   <= ovf;
      s1_r.pix   <= (fn == FUNC_PIXEL);
      m0_r       <= m0;
      m1_r       <= m1;
      for (int i = 0; i < NUM_LANES; i++) ctl_r[i] <= ctl[i];
    end
  end

  // message store: one write port, two read ports for the byte pair
  always_ff @(posedge clk) begin
    if (in_fire && wr_en) mem[len_r[AW-1:0]] <= msg_byte;
    if (in_fire) begin
      rd0_r <= mem[idx0[AW-1:0]];
      rd1_r <= mem[idx1[AW-1:0]];
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;
  assign byte0    = m0_r ? rd0_r : 8'd0;
  assign byte1    = m1_r ? rd1_r : 8'd0;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) lane_ctl[i] = ctl_r[i];
  end

endmodule

// ===== hw/rtl/lsbse_lane.sv =====
// one color channel: replaces the lsb with the selected message bit
module lsbse_lane import lsbse_pkg::*; (
  input  logic [7:0] ch_in,
  input  lane_ctl_t  ctl,
  input  logic [7:0] byte0,
  input  logic [7:0] byte1,
  output logic [7:0] ch_out
);

  logic [7:0] src;

  assign src    = ctl.hi ? byte1 : byte0;
  assign ch_out = ctl.en ? {ch_in[7:1], src[ctl.bitnum]} : ch_in;

endmodule

// ===== hw/rtl/lsbse_merge.sv =====
// gathers the lane results into the output word register
module lsbse_merge import lsbse_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s1_valid,
  input  s1_t                   s1,
  input  logic [7:0]            lane_out [NUM_LANES],
  output logic                  s2_ready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  assign s2_ready = !out_valid_r || out_tready;

  always_comb begin
    out_data_nxt = '0;
    if (s1.pix) begin
      out_data_nxt[7:0]   = lane_out[0];
      out_data_nxt[15:8]  = lane_out[1];
      out_data_nxt[23:16] = lane_out[2];
      out_data_nxt[31:24] = s1.alpha;
      out_data_nxt[33:32] = s1.used;
    end
    out_data_nxt[34] = s1.done;
    out_data_nxt[35] = s1.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/lsb_stego_embed_top.sv =====
// lsb stego embed: an accepted word is registered in the read stage, then in the output word register
// throughput one word per cycle while out_tready does not stall, any mix of start, append and pixel words
// rate set by the two-port message store read and the three embed lanes
// rst_n synchronous active low: empties the message and rewinds the bit position
// store contents are not cleared; bytes beyond the message read as zero
module lsb_stego_embed_top import lsbse_pkg::*; #(
  parameter int MSG_DEPTH = MSG_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // msg_byte, red_in, green_in, blue_in, alpha_in
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func
  input  logic [1:0]            in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // red_out, green_out, blue_out, alpha_out, bits_used, message_done, store_overflow
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic       s1_valid, s2_ready;
  s1_t        s1;
  lane_ctl_t  lane_ctl [NUM_LANES];
  logic [7:0] byte0, byte1;
  logic [7:0] lane_in  [NUM_LANES];
  logic [7:0] lane_out [NUM_LANES];

  lsbse_ctrl #(.MSG_DEPTH(MSG_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_func    (in_tuser),
    .msg_byte   (in_tdata[7:0]),
    .red_in     (in_tdata[15:8]),
    .green_in   (in_tdata[23:16]),
    .blue_in    (in_tdata[31:24]),
    .alpha_in   (in_tdata[39:32]),
    .last_pixel (in_tlast),
    .s2_ready   (s2_ready),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .lane_ctl   (lane_ctl),
    .byte0      (byte0),
    .byte1      (byte1)
  );

  assign lane_in[0] = s1.red;
  assign lane_in[1] = s1.green;
  assign lane_in[2] = s1.blue;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lsbse_lane u_lane (
      .ch_in  (lane_in[g]),
      .ctl    (lane_ctl[g]),
      .byte0  (byte0),
      .byte1  (byte1),
      .ch_out (lane_out[g])
    );
  end

  lsbse_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .lane_out   (lane_out),
    .s2_ready   (s2_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hw/rtl/lsbse_checker.sv =====
// port-level checks on the output stream of the embedder
module lsbse_sva import lsbse_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // reset leaves no word pending
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

  // a dropped byte never carries pixel data
  a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[35] |-> out_tdata[33:0] == 34'd0)
    else $error("overflow word carries pixel fields");

  // a partly filled pixel only happens at the end of the message
  a_partial_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[33:32] == 2'd1 || out_tdata[33:32] == 2'd2)
      |-> out_tdata[34])
    else $error("partial pixel without message done");

endmodule

bind lsb_stego_embed_top lsbse_sva u_lsbse_sva (.*);
